// ===== rtl/core/rtgm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtgm_pkg
// Shared types and constants of the radar target time gap monitor.
// ----------------------------------------------------------------------------
package rtgm_pkg;

   // default field widths of the target vectors
   localparam int DEF_POS_WIDTH = 20;
   localparam int DEF_VEL_WIDTH = 18;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_HORIZONTAL  = 3'd0,
      CSR_MIN_RANGE       = 3'd1,
      CSR_MIN_FOLLOWER    = 3'd2,
      CSR_CORRIDOR_HALF   = 3'd3,
      CSR_GAP_LIMIT       = 3'd4,
      CSR_APPROACH_THRESH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               use_horizontal;
      logic [19:0]        min_range_mm;
      logic [17:0]        min_follower_speed;
      logic [18:0]        corridor_half_width_mm;
      logic [15:0]        gap_limit_ms;
      logic signed [18:0] approach_threshold;
   } cfg_type;

   // register reset values
   localparam logic [19:0]        RST_MIN_RANGE  = 20'd100;
   localparam logic [17:0]        RST_MIN_FOLLOW = 18'd500;
   localparam logic [18:0]        RST_CORRIDOR   = 19'd0;
   localparam logic [15:0]        RST_GAP_LIMIT  = 16'd2000;
   localparam logic signed [18:0] RST_APPROACH   = 19'sd5000;

   // result limits and codes
   localparam logic [15:0]        GAP_INF     = 16'hFFFF;
   localparam logic [15:0]        GAP_CAP     = 16'hFFFE;
   localparam logic [19:0]        RANGE_MAX   = 20'hFFFFF;
   localparam logic [17:0]        GROUND_MAX  = 18'h3FFFF;
   localparam logic signed [18:0] CLOSE_MAX   = 19'sd262143;
   localparam logic signed [18:0] CLOSE_MIN   = -19'sd262144;
   localparam int                 MS_PER_SEC  = 1000;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_SQ_INIT,
      OP_SQ_STEP,
      OP_ROOT,
      OP_DC_INIT,
      OP_DIV_STEP,
      OP_CL_FIN,
      OP_PRD_A,
      OP_PRD_B,
      OP_DT_INIT,
      OP_GAP_FIN,
      OP_EMIT
   } op_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic mul_last;
      logic sq_last;
      logic div_last;
      logic tgt_valid;
      logic follower;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/core/rtgm_req_if.sv =====
// ----------------------------------------------------------------------------
// rtgm_req_if
// Target channel: one radar target per transfer.
// ----------------------------------------------------------------------------
interface rtgm_req_if
   import rtgm_pkg::*;
#(
   parameter int POS_WIDTH = DEF_POS_WIDTH,
   parameter int VEL_WIDTH = DEF_VEL_WIDTH
);
   logic                        valid;
   logic                        ready;
   logic [7:0]                  target_id;
   logic signed [POS_WIDTH-1:0] pos_x;
   logic signed [POS_WIDTH-1:0] pos_y;
   logic signed [POS_WIDTH-1:0] pos_z;
   logic signed [VEL_WIDTH-1:0] vel_x;
   logic signed [VEL_WIDTH-1:0] vel_y;
   logic signed [VEL_WIDTH-1:0] vel_z;
   logic [16:0]                 own_speed;
   logic                        data_ok;
   logic                        frame_last;

   modport source (output valid, target_id, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   own_speed, data_ok, frame_last, input ready);
   modport sink   (input valid, target_id, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   own_speed, data_ok, frame_last, output ready);
endinterface

// ===== rtl/core/rtgm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rtgm_rsp_if
// Result channel: one target assessment plus frame aggregates per transfer.
// ----------------------------------------------------------------------------
interface rtgm_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         result_id;
   logic               target_valid;
   logic [19:0]        range_mm;
   logic signed [18:0] closing_speed;
   logic [17:0]        ground_speed;
   logic [15:0]        time_gap_ms;
   logic [3:0]         target_flags;
   logic               any_gap_violation;
   logic               any_approach_alert;
   logic [15:0]        min_time_gap_ms;
   logic signed [18:0] max_closing;
   logic               result_last;

   modport source (output valid, result_id, target_valid, range_mm, closing_speed,
                   ground_speed, time_gap_ms, target_flags, any_gap_violation,
                   any_approach_alert, min_time_gap_ms, max_closing, result_last,
                   input ready);
   modport sink   (input valid, result_id, target_valid, range_mm, closing_speed,
                   ground_speed, time_gap_ms, target_flags, any_gap_violation,
                   any_approach_alert, min_time_gap_ms, max_closing, result_last,
                   output ready);
endinterface

// ===== rtl/core/rtgm_csr.sv =====
// ----------------------------------------------------------------------------
// rtgm_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rtgm_csr
   import rtgm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_USE_HORIZONTAL:  cfg_in.use_horizontal         = csr_wdata[0];
            CSR_MIN_RANGE:       cfg_in.min_range_mm           = csr_wdata[19:0];
            CSR_MIN_FOLLOWER:    cfg_in.min_follower_speed     = csr_wdata[17:0];
            CSR_CORRIDOR_HALF:   cfg_in.corridor_half_width_mm = csr_wdata[18:0];
            CSR_GAP_LIMIT:       cfg_in.gap_limit_ms           = csr_wdata[15:0];
            CSR_APPROACH_THRESH: cfg_in.approach_threshold     = signed'(csr_wdata[18:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_horizontal         <= 1'b0;
         cfg_ff.min_range_mm           <= RST_MIN_RANGE;
         cfg_ff.min_follower_speed     <= RST_MIN_FOLLOW;
         cfg_ff.corridor_half_width_mm <= RST_CORRIDOR;
         cfg_ff.gap_limit_ms           <= RST_GAP_LIMIT;
         cfg_ff.approach_threshold     <= RST_APPROACH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== rtl/core/rtgm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtgm_ctrl
// Sequencer: steps the datapath through products, root, divisions and emit.
// ----------------------------------------------------------------------------
module rtgm_ctrl
   import rtgm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output op_type        op
);
   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_SQI, S_SQ, S_ROOT, S_CHK, S_DIVC, S_CLF,
      S_PRA, S_PRB, S_DTI, S_DIVT, S_GAPF, S_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and operation
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            op = OP_MUL;
            if (status.mul_last) state_in = S_SQI;
         end
         S_SQI: begin
            op       = OP_SQ_INIT;
            state_in = S_SQ;
         end
         S_SQ: begin
            op = OP_SQ_STEP;
            if (status.sq_last) state_in = S_ROOT;
         end
         S_ROOT: begin
            op       = OP_ROOT;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (status.tgt_valid) begin
               op       = OP_DC_INIT;
               state_in = S_DIVC;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIVC: begin
            op = OP_DIV_STEP;
            if (status.div_last) state_in = S_CLF;
         end
         S_CLF: begin
            op       = OP_CL_FIN;
            state_in = status.follower ? S_PRA : S_FIN;
         end
         S_PRA: begin
            op       = OP_PRD_A;
            state_in = S_PRB;
         end
         S_PRB: begin
            op       = OP_PRD_B;
            state_in = S_DTI;
         end
         S_DTI: begin
            op       = OP_DT_INIT;
            state_in = S_DIVT;
         end
         S_DIVT: begin
            op = OP_DIV_STEP;
            if (status.div_last) state_in = S_GAPF;
         end
         S_GAPF: begin
            op       = OP_GAP_FIN;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (status.rsp_free) begin
               op       = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
endmodule

// ===== rtl/core/rtgm_dp.sv =====
// ----------------------------------------------------------------------------
// rtgm_dp
// Datapath: shared multiplier, bit-serial root, shared restoring divider,
// result register and frame aggregates.
// ----------------------------------------------------------------------------
module rtgm_dp
   import rtgm_pkg::*;
#(
   parameter int POS_WIDTH = DEF_POS_WIDTH,
   parameter int VEL_WIDTH = DEF_VEL_WIDTH
)(
   input  logic          clock,
   input  logic          reset,
   rtgm_req_if.sink      req_ch,
   rtgm_rsp_if.source    rsp_ch,
   input  cfg_type       cfg,
   input  op_type        op,
   output dp_status_type status
);
   localparam int PW   = POS_WIDTH;
   localparam int VW   = VEL_WIDTH;
   localparam int SQW  = 2 * PW + 2;               // sum of squares
   localparam int SQN  = SQW / 2;                  // root iterations
   localparam int RRW  = PW + 2;                   // rounded range
   localparam int DW   = PW + VW;                  // dot product magnitude
   localparam int GW   = ((VW > 17) ? VW : 17) + 1; // ground speed
   localparam int GSW  = GW + 1;
   localparam int RKW  = RRW + 10;                 // range times 1000
   localparam int NW   = ((DW + 1) > (RKW + 1)) ? (DW + 1) : (RKW + 1);
   localparam int DVW  = (RRW > GW) ? RRW : GW;
   localparam int AW   = RRW;
   localparam int BW0  = (PW > VW) ? PW : VW;
   localparam int BW   = (BW0 > GW) ? BW0 : GW;
   localparam int PRW  = AW + BW;
   localparam int CSW  = NW + 1;
   localparam int RCW  = (RRW > 20) ? RRW : 20;
   localparam int XCW  = (PW > 19) ? PW : 19;
   localparam int CMX  = (NW > SQN) ? NW : SQN;
   localparam int CW   = $clog2(CMX + 1);
   localparam int MUL_LAST = 6;

   // captured target
   logic [7:0]          id_ff;
   logic signed [PW-1:0] x_ff, y_ff, z_ff;
   logic signed [VW-1:0] vx_ff, vy_ff, vz_ff;
   logic [16:0]         own_ff;
   logic                ok_ff, last_ff;

   logic [CW-1:0]       cnt_ff;
   logic [PRW-1:0]      prod_ff;
   logic                pneg_ff, psq_ff, pen_ff;
   logic [SQW-1:0]      sq_ff;
   logic [DW-1:0]       dpos_ff, dneg_ff;
   logic [SQW-1:0]      srem_ff, sres_ff, sbit_ff;
   logic [RRW-1:0]      r_ff;
   logic                cneg_ff;
   logic [NW-1:0]       quo_ff;
   logic [DVW:0]        rem_ff;
   logic [DVW-1:0]      den_ff;
   logic signed [CSW-1:0] close_ff;
   logic [RKW-1:0]      rk_ff;
   logic                viol_ff;
   logic [15:0]         gap_ff;

   // frame aggregates
   logic                gvs_ff, aas_ff;
   logic [15:0]         lg_ff;
   logic signed [18:0]  hc_ff;

   // result register
   logic                rsp_valid_ff;
   logic [7:0]          o_id_ff;
   logic                o_valid_ff;
   logic [19:0]         o_range_ff;
   logic signed [18:0]  o_close_ff;
   logic [17:0]         o_ground_ff;
   logic [15:0]         o_gap_ff;
   logic [3:0]          o_flags_ff;
   logic                o_gv_ff, o_aa_ff;
   logic [15:0]         o_lg_ff;
   logic signed [18:0]  o_hc_ff;
   logic                o_last_ff;

   // magnitudes and sign-free ground speed
   logic [PW-1:0] mx, my, mz;
   logic [VW-1:0] mvx, mvy, mvz;
   logic signed [GSW-1:0] g_s;
   logic [GW-1:0] gu;
   logic follower, corridor, tgt_valid;

   assign mx  = x_ff[PW-1]  ? (~x_ff + 1'b1)  : x_ff;
   assign my  = y_ff[PW-1]  ? (~y_ff + 1'b1)  : y_ff;
   assign mz  = z_ff[PW-1]  ? (~z_ff + 1'b1)  : z_ff;
   assign mvx = vx_ff[VW-1] ? (~vx_ff + 1'b1) : vx_ff;
   assign mvy = vy_ff[VW-1] ? (~vy_ff + 1'b1) : vy_ff;
   assign mvz = vz_ff[VW-1] ? (~vz_ff + 1'b1) : vz_ff;

   assign g_s = GSW'(signed'({1'b0, own_ff})) - GSW'(vy_ff);
   assign gu  = g_s[GSW-1] ? '0 : g_s[GW-1:0];

   assign follower  = gu > GW'(cfg.min_follower_speed);
   assign corridor  = (cfg.corridor_half_width_mm == '0) ||
                      (XCW'(mx) <= XCW'(cfg.corridor_half_width_mm));
   assign tgt_valid = ok_ff && (r_ff != '0) && (RCW'(r_ff) >= RCW'(cfg.min_range_mm));

   // multiplier operand select
   logic [AW-1:0] a_op;
   logic [BW-1:0] b_op;
   logic          s_neg, s_sq, s_en;
   logic [PRW-1:0] mul;

   always_comb begin
      a_op  = '0;
      b_op  = '0;
      s_neg = 1'b0;
      s_sq  = 1'b1;
      s_en  = 1'b1;
      case (op)
         OP_PRD_A: begin
            a_op = r_ff;
            b_op = BW'(MS_PER_SEC);
         end
         OP_PRD_B: begin
            a_op = AW'(cfg.gap_limit_ms);
            b_op = BW'(gu);
         end
         default: begin
            case (cnt_ff[2:0])
               3'd0: begin a_op = AW'(mx); b_op = BW'(mx); end
               3'd1: begin a_op = AW'(my); b_op = BW'(my); end
               3'd2: begin
                  a_op = AW'(mz); b_op = BW'(mz);
                  s_en = !cfg.use_horizontal;
               end
               3'd3: begin
                  a_op = AW'(mx); b_op = BW'(mvx); s_sq = 1'b0;
                  s_neg = x_ff[PW-1] ^ vx_ff[VW-1];
               end
               3'd4: begin
                  a_op = AW'(my); b_op = BW'(mvy); s_sq = 1'b0;
                  s_neg = y_ff[PW-1] ^ vy_ff[VW-1];
               end
               3'd5: begin
                  a_op = AW'(mz); b_op = BW'(mvz); s_sq = 1'b0;
                  s_neg = z_ff[PW-1] ^ vz_ff[VW-1];
                  s_en = !cfg.use_horizontal;
               end
               default: ;
            endcase
         end
      endcase
   end

   assign mul = PRW'(a_op) * PRW'(b_op);

   // root and divider step terms
   logic [SQW-1:0] s_try;
   logic [DVW:0]   d_try;
   logic           d_ge;
   logic [DW-1:0]  dm;

   assign s_try = sres_ff + sbit_ff;
   assign d_try = {rem_ff[DVW-1:0], quo_ff[NW-1]};
   assign d_ge  = d_try >= {1'b0, den_ff};
   assign dm    = (dpos_ff > dneg_ff) ? (dpos_ff - dneg_ff) : (dneg_ff - dpos_ff);

   // result formatting and aggregate update
   logic [RCW-1:0]     rc;
   logic [19:0]        e_range;
   logic signed [18:0] e_close;
   logic [17:0]        e_ground;
   logic [15:0]        e_gap;
   logic [3:0]         e_flags;
   logic               e_appr;
   logic               e_gv, e_aa;
   logic [15:0]        e_lg;
   logic signed [18:0] e_hc;

   assign rc = RCW'(r_ff);

   always_comb begin
      e_appr   = close_ff > CSW'(cfg.approach_threshold);
      e_range  = '0;
      e_close  = '0;
      e_ground = '0;
      e_gap    = GAP_INF;
      e_flags  = '0;
      e_gv     = gvs_ff;
      e_aa     = aas_ff;
      e_lg     = lg_ff;
      e_hc     = hc_ff;
      if (tgt_valid) begin
         e_range  = (rc > RCW'(RANGE_MAX)) ? RANGE_MAX : rc[19:0];
         if (close_ff > CSW'(CLOSE_MAX))      e_close = CLOSE_MAX;
         else if (close_ff < CSW'(CLOSE_MIN)) e_close = CLOSE_MIN;
         else                                 e_close = close_ff[18:0];
         e_ground = (gu > GW'(GROUND_MAX)) ? GROUND_MAX : gu[17:0];
         e_gap    = gap_ff;
         e_flags  = {e_appr, viol_ff, corridor, follower};
         e_gv     = gvs_ff | viol_ff;
         e_aa     = aas_ff | e_appr;
         if (follower && corridor && (gap_ff < lg_ff)) e_lg = gap_ff;
         if (e_close > hc_ff)                          e_hc = e_close;
      end
   end

   // sequenced datapath registers
   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            id_ff   <= req_ch.target_id;
            x_ff    <= req_ch.pos_x;
            y_ff    <= req_ch.pos_y;
            z_ff    <= req_ch.pos_z;
            vx_ff   <= req_ch.vel_x;
            vy_ff   <= req_ch.vel_y;
            vz_ff   <= req_ch.vel_z;
            own_ff  <= req_ch.own_speed;
            ok_ff   <= req_ch.data_ok;
            last_ff <= req_ch.frame_last;
            cnt_ff  <= '0;
            sq_ff   <= '0;
            dpos_ff <= '0;
            dneg_ff <= '0;
            viol_ff <= 1'b0;
            gap_ff  <= GAP_INF;
         end
         OP_MUL: begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff != '0 && pen_ff) begin
               if (psq_ff)       sq_ff   <= sq_ff + SQW'(prod_ff);
               else if (pneg_ff) dneg_ff <= dneg_ff + DW'(prod_ff);
               else              dpos_ff <= dpos_ff + DW'(prod_ff);
            end
            prod_ff <= mul;
            pneg_ff <= s_neg;
            psq_ff  <= s_sq;
            pen_ff  <= s_en;
         end
         OP_SQ_INIT: begin
            cnt_ff  <= '0;
            srem_ff <= sq_ff;
            sres_ff <= '0;
            sbit_ff <= SQW'(1) << (SQW - 2);
         end
         OP_SQ_STEP: begin
            cnt_ff <= cnt_ff + 1'b1;
            if (srem_ff >= s_try) begin
               srem_ff <= srem_ff - s_try;
               sres_ff <= (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_ff <= sres_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
         end
         OP_ROOT: begin
            r_ff <= RRW'((srem_ff > sres_ff) ? (sres_ff + 1'b1) : sres_ff);
         end
         OP_DC_INIT: begin
            cnt_ff  <= '0;
            cneg_ff <= dpos_ff > dneg_ff;
            quo_ff  <= NW'(dm) + NW'(r_ff >> 1);
            den_ff  <= DVW'(r_ff);
            rem_ff  <= '0;
         end
         OP_DIV_STEP: begin
            cnt_ff <= cnt_ff + 1'b1;
            rem_ff <= d_ge ? (d_try - {1'b0, den_ff}) : d_try;
            quo_ff <= {quo_ff[NW-2:0], d_ge};
         end
         OP_CL_FIN: begin
            close_ff <= cneg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
         end
         OP_PRD_A: begin
            prod_ff <= mul;
         end
         OP_PRD_B: begin
            rk_ff   <= prod_ff[RKW-1:0];
            prod_ff <= mul;
         end
         OP_DT_INIT: begin
            cnt_ff  <= '0;
            viol_ff <= follower && corridor && (PRW'(rk_ff) < prod_ff);
            quo_ff  <= NW'(rk_ff) + NW'(gu >> 1);
            den_ff  <= DVW'(gu);
            rem_ff  <= '0;
         end
         OP_GAP_FIN: begin
            gap_ff <= (quo_ff > NW'(GAP_CAP)) ? GAP_CAP : quo_ff[15:0];
         end
         default: ;
      endcase
   end

   // result payload
   always_ff @(posedge clock) begin
      if (op == OP_EMIT) begin
         o_id_ff     <= id_ff;
         o_valid_ff  <= tgt_valid;
         o_range_ff  <= e_range;
         o_close_ff  <= e_close;
         o_ground_ff <= e_ground;
         o_gap_ff    <= e_gap;
         o_flags_ff  <= e_flags;
         o_gv_ff     <= e_gv;
         o_aa_ff     <= e_aa;
         o_lg_ff     <= e_lg;
         o_hc_ff     <= e_hc;
         o_last_ff   <= last_ff;
      end
   end

   // result valid and frame aggregates
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         gvs_ff       <= 1'b0;
         aas_ff       <= 1'b0;
         lg_ff        <= GAP_INF;
         hc_ff        <= CLOSE_MIN;
      end else begin
         if (op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               gvs_ff <= 1'b0;
               aas_ff <= 1'b0;
               lg_ff  <= GAP_INF;
               hc_ff  <= CLOSE_MIN;
            end else begin
               gvs_ff <= e_gv;
               aas_ff <= e_aa;
               lg_ff  <= e_lg;
               hc_ff  <= e_hc;
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // status to the controller
   assign status.mul_last  = (cnt_ff == CW'(MUL_LAST));
   assign status.sq_last   = (cnt_ff == CW'(SQN - 1));
   assign status.div_last  = (cnt_ff == CW'(NW - 1));
   assign status.tgt_valid = tgt_valid;
   assign status.follower  = follower;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.result_id          = o_id_ff;
   assign rsp_ch.target_valid       = o_valid_ff;
   assign rsp_ch.range_mm           = o_range_ff;
   assign rsp_ch.closing_speed      = o_close_ff;
   assign rsp_ch.ground_speed       = o_ground_ff;
   assign rsp_ch.time_gap_ms        = o_gap_ff;
   assign rsp_ch.target_flags       = o_flags_ff;
   assign rsp_ch.any_gap_violation  = o_gv_ff;
   assign rsp_ch.any_approach_alert = o_aa_ff;
   assign rsp_ch.min_time_gap_ms    = o_lg_ff;
   assign rsp_ch.max_closing        = o_hc_ff;
   assign rsp_ch.result_last        = o_last_ff;

   // aggregates restart after the last target of a frame
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EMIT && last_ff) |=>
         (lg_ff == GAP_INF && hc_ff == CLOSE_MIN && !gvs_ff && !aas_ff))
      else $error("frame aggregates not cleared after last target");

   // an invalid target reports zero range and no flags
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EMIT && !tgt_valid) |=>
         (rsp_ch.range_mm == '0 && rsp_ch.target_flags == '0 &&
          rsp_ch.time_gap_ms == GAP_INF))
      else $error("invalid target carries results");

   // non-followers never get a finite gap
   a_nonfollow_gap: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EMIT && tgt_valid && !follower) |-> (gap_ff == GAP_INF && !viol_ff))
      else $error("finite gap on a non-follower");

   // an emitted result is presented on the following cycle
   a_emit_sent: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EMIT) |=> rsp_valid_ff)
      else $error("emitted result not presented");
endmodule

// ===== rtl/core/radar_target_time_gap_monitor_core.sv =====
// ----------------------------------------------------------------------------
// radar_target_time_gap_monitor_core
// Per-target range, closing speed, ground speed and time gap with frame
// aggregates.
// ----------------------------------------------------------------------------
// One target is worked on at a time. The time from its transfer to the next
// target's transfer is longer when the target is valid than when it turns out
// invalid, longer again when it is a follower, and includes any wait of the
// finished result for the previous one to leave the output register. It is set
// by the bit-serial square root and by the restoring divider, which yields one
// quotient bit per cycle over an NW-bit quotient, NW = max(POS_WIDTH +
// VEL_WIDTH + 1, POS_WIDTH + 13), and is shared by the closing speed and the
// time gap. Products go through one shared multiplier. The finished result
// sits in an output register, so the next target is taken while it waits.
module radar_target_time_gap_monitor_core
   import rtgm_pkg::*;
#(
   parameter int POS_WIDTH = DEF_POS_WIDTH,
   parameter int VEL_WIDTH = DEF_VEL_WIDTH
)(
   input  logic                  clock,
   input  logic                  reset,
   rtgm_req_if.sink              req_ch,
   rtgm_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type       cfg;
   op_type        op;
   dp_status_type status;
   logic          req_ready;

   rtgm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rtgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   rtgm_dp #(
      .POS_WIDTH (POS_WIDTH),
      .VEL_WIDTH (VEL_WIDTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cfg    (cfg),
      .op     (op),
      .status (status)
   );

   assign req_ch.ready = req_ready;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radar target time gap monitor core. Targets go
// in through the request channel with random gaps; an in-bench assessor
// predicts every result, including the running frame aggregates, and each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import rtgm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 2000;

   typedef struct {
      logic [7:0]         id;
      logic signed [19:0] px, py, pz;
      logic signed [17:0] vx, vy, vz;
      logic [16:0]        own;
      logic               ok, last;
   } target_type;

   typedef struct {
      logic [7:0]         id;
      logic               tv;
      logic [19:0]        rng;
      logic signed [18:0] cls;
      logic [17:0]        gnd;
      logic [15:0]        gap;
      logic [3:0]         flg;
      logic               agv, aap;
      logic [15:0]        mgap;
      logic signed [18:0] mcls;
      logic               last;
   } assess_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rtgm_req_if req_ch ();
   rtgm_rsp_if rsp_ch ();

   radar_target_time_gap_monitor_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // assessor copy of the configuration and the frame aggregates
   logic    horiz;
   longint  min_rng, min_follow, corridor, gap_lim, appr_thr;
   logic    gap_seen, appr_seen;
   longint  low_gap, high_close;

   assess_type expected_q[$];
   int      errors;
   int      src_idle_pct;
   int      snk_idle_pct;
   logic    start_hold;
   int      hold_left;
   int      quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- assessor
   function automatic longint unsigned root_rounded(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return (n > res) ? res + 1 : res;
   endfunction

   function automatic void clear_frame();
      gap_seen   = 1'b0;
      appr_seen  = 1'b0;
      low_gap    = 65535;
      high_close = -262144;
   endfunction

   function automatic assess_type assess_target(target_type t);
      assess_type a;
      longint x, y, z, vx, vy, vz, dot, dm, qm, closing, g, ax, tg;
      longint unsigned sq, r;
      logic   valid, follower, in_corr, viol, appr;
      x = t.px; y = t.py; z = t.pz;
      vx = t.vx; vy = t.vy; vz = t.vz;
      sq  = x * x + y * y;
      dot = x * vx + y * vy;
      if (!horiz) begin
         sq  += z * z;
         dot += z * vz;
      end
      r = root_rounded(sq);
      valid = t.ok && r != 0 && longint'(r) >= min_rng;
      a = '{id: t.id, tv: valid, rng: 0, cls: 0, gnd: 0, gap: GAP_INF, flg: 0,
            agv: 0, aap: 0, mgap: 0, mcls: 0, last: t.last};
      if (valid) begin
         dm = (dot < 0) ? -dot : dot;
         qm = (dm + longint'(r / 2)) / longint'(r);
         closing = (dot > 0) ? -qm : qm;
         g  = longint'(t.own) - vy;
         if (g < 0) g = 0;
         ax = (x < 0) ? -x : x;
         follower = g > min_follow;
         in_corr  = corridor == 0 || ax <= corridor;
         if (follower) begin
            tg    = (longint'(r) * 1000 + g / 2) / g;
            a.gap = (tg > 65534) ? GAP_CAP : tg[15:0];
         end
         viol = follower && in_corr && (longint'(r) * 1000 < gap_lim * g);
         appr = closing > appr_thr;
         a.rng = (r > 64'hFFFFF) ? RANGE_MAX : r[19:0];
         if (closing > 262143) closing = 262143;
         if (closing < -262144) closing = -262144;
         a.cls = closing[18:0];
         a.gnd = (g > 262143) ? GROUND_MAX : g[17:0];
         a.flg = {appr, viol, in_corr, follower};
         // frame aggregates include the current target
         if (viol) gap_seen = 1'b1;
         if (appr) appr_seen = 1'b1;
         if (follower && in_corr && longint'(a.gap) < low_gap) low_gap = a.gap;
         if (closing > high_close) high_close = closing;
      end
      a.agv  = gap_seen;
      a.aap  = appr_seen;
      a.mgap = low_gap[15:0];
      a.mcls = high_close[18:0];
      if (t.last) clear_frame();
      return a;
   endfunction

   // ---------------------------------------------------------------- checker
   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      assess_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $error("result transfer with no target outstanding");
            errors++;
         end else begin
            e = expected_q.pop_front();
            check_field("result_id", e.id, rsp_ch.result_id);
            check_field("target_valid", e.tv, rsp_ch.target_valid);
            check_field("range_mm", e.rng, rsp_ch.range_mm);
            check_field("closing_speed", e.cls, rsp_ch.closing_speed);
            check_field("ground_speed", e.gnd, rsp_ch.ground_speed);
            check_field("time_gap_ms", e.gap, rsp_ch.time_gap_ms);
            check_field("target_flags", e.flg, rsp_ch.target_flags);
            check_field("any_gap_violation", e.agv, rsp_ch.any_gap_violation);
            check_field("any_approach_alert", e.aap, rsp_ch.any_approach_alert);
            check_field("min_time_gap_ms", e.mgap, rsp_ch.min_time_gap_ms);
            check_field("max_closing", e.mcls, rsp_ch.max_closing);
            check_field("result_last", e.last, rsp_ch.result_last);
         end
      end
   end

   // result-side ready: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (start_hold) begin
         hold_left     <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_target(target_type t);
      assess_type pred;
      if ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < src_idle_pct) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.target_id  <= t.id;
      req_ch.pos_x      <= t.px;
      req_ch.pos_y      <= t.py;
      req_ch.pos_z      <= t.pz;
      req_ch.vel_x      <= t.vx;
      req_ch.vel_y      <= t.vy;
      req_ch.vel_z      <= t.vz;
      req_ch.own_speed  <= t.own;
      req_ch.data_ok    <= t.ok;
      req_ch.frame_last <= t.last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = assess_target(t);
      expected_q.insert(expected_q.size(), pred);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // all six registers, written back to back while the core is idle
   task automatic apply_config(logic h, longint mr, longint mf, longint cw,
                               longint gl, longint th);
      logic [18:0] th_bits;
      th_bits = th[18:0];
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_USE_HORIZONTAL;  csr_wdata <= {19'd0, h};     @(posedge clock);
      csr_index <= CSR_MIN_RANGE;       csr_wdata <= mr[19:0];       @(posedge clock);
      csr_index <= CSR_MIN_FOLLOWER;    csr_wdata <= mf[19:0];       @(posedge clock);
      csr_index <= CSR_CORRIDOR_HALF;   csr_wdata <= cw[19:0];       @(posedge clock);
      csr_index <= CSR_GAP_LIMIT;       csr_wdata <= gl[19:0];       @(posedge clock);
      csr_index <= CSR_APPROACH_THRESH; csr_wdata <= {1'b0, th_bits}; @(posedge clock);
      csr_we <= 1'b0;
      horiz = h; min_rng = mr; min_follow = mf; corridor = cw; gap_lim = gl;
      appr_thr = longint'($signed(th_bits));
   endtask

   function automatic target_type make_target(longint px, longint py, longint pz,
                                              longint vx, longint vy, longint vz,
                                              longint own, logic ok, logic last);
      target_type t;
      t.id = $urandom; t.px = px; t.py = py; t.pz = pz;
      t.vx = vx; t.vy = vy; t.vz = vz; t.own = own; t.ok = ok; t.last = last;
      return t;
   endfunction

   // mostly plausible road scenes, some full-range noise
   function automatic target_type random_target();
      target_type t;
      int      kind;
      kind = $urandom_range(9);
      t.id = $urandom;
      if (kind < 3) begin
         t.px = $urandom; t.py = $urandom; t.pz = $urandom;
         t.vx = $urandom; t.vy = $urandom; t.vz = $urandom;
         t.own = $urandom;
      end else begin
         t.px = $signed($urandom_range(8000)) - 4000;
         t.py = $urandom_range(200000);
         t.pz = $signed($urandom_range(2000)) - 1000;
         t.vx = $signed($urandom_range(4000)) - 2000;
         t.vy = $signed($urandom_range(80000)) - 60000;
         t.vz = $signed($urandom_range(400)) - 200;
         t.own = $urandom_range(40000);
         if (kind == 9) begin
            t.py = $signed($urandom_range(400)) - 200;
            t.px = $signed($urandom_range(400)) - 200;
         end
      end
      t.ok   = ($urandom_range(19) != 0);
      t.last = ($urandom_range(5) == 0);
      return t;
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      send_target(make_target(0, 0, 0, 0, 0, 0, 0, 1, 0));                 // zero range
      send_target(make_target(5000, 20000, 0, 0, -3000, 0, 20000, 0, 0));  // data not ok
      send_target(make_target(30, 40, 0, 0, 0, 0, 1000, 1, 1));            // below min range
      send_target(make_target(524287, 524287, 524287, 131071, 131071, 131071,
                              131071, 1, 0));
      send_target(make_target(-524288, -524288, -524288, -131072, -131072, -131072,
                              0, 1, 0));
      send_target(make_target(-524288, -524288, -524288, 131071, 131071, 131071,
                              131071, 1, 1));
      send_target(make_target(0, 20000, 0, 0, -20000, 0, 10000, 1, 0));   // violation
      send_target(make_target(0, 20000, 0, 0, 5000, 0, 5000, 1, 0));      // not follower
      send_target(make_target(0, 524287, 524287, 0, 0, 0, 501, 1, 0));    // gap capped
      send_target(make_target(100, 1000, 0, -300, -131072, 0, 0, 1, 1));  // approach
      send_target(make_target(0, 0, 1, 0, 0, 0, 0, 1, 1));                // empty frame
      send_target(make_target(3, 4, 0, 1, 1, 0, 0, 1, 0));                // odd rounding
   endtask

   task automatic test_random(int n);
      repeat (n) send_target(random_target());
   endtask

   task automatic test_backpressure();
      drain();
      start_hold <= 1'b1;
      @(posedge clock);
      start_hold <= 1'b0;
      test_random(8);
   endtask

   initial begin
      errors = 0;
      src_idle_pct = 9;
      snk_idle_pct = 53;
      start_hold = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_USE_HORIZONTAL;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.target_id = '0;
      req_ch.pos_x = '0; req_ch.pos_y = '0; req_ch.pos_z = '0;
      req_ch.vel_x = '0; req_ch.vel_y = '0; req_ch.vel_z = '0;
      req_ch.own_speed = '0;
      req_ch.data_ok = 1'b0;
      req_ch.frame_last = 1'b0;
      horiz = 0; min_rng = 100; min_follow = 500; corridor = 0; gap_lim = 2000;
      appr_thr = 5000;
      clear_frame();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(120);
      apply_config(1'b1, 0, 0, 1000, 65535, -262144);
      test_directed();
      test_random(100);
      test_backpressure();

      src_idle_pct = 53;
      snk_idle_pct = 9;
      apply_config(1'b0, 1048575, 262143, 524287, 0, 262143);
      test_directed();
      apply_config(1'b0, 50, 262143, 524287, 0, 262143);
      test_random(80);
      apply_config($urandom_range(1), $urandom_range(2000), $urandom_range(3000),
                   $urandom_range(5000), $urandom_range(4000),
                   longint'($urandom_range(20000)) - 10000);
      test_random(100);

      src_idle_pct = 0;
      snk_idle_pct = 0;
      apply_config(1'b0, 100, 500, 2500, 3000, 0);
      test_random(120);
      drain();

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
